FILE: rtl/phr_pkg.sv
// Shared types and constants for the ppm/HSV to RGB565 color converter.
package phr_pkg;

  // Hue sector widths and ppm mapping constants
  localparam logic [7:0]  REGION_WIDTH = 8'd43;
  localparam logic [10:0] PPM_LOW      = 11'd800;
  localparam logic [10:0] PPM_HIGH     = 11'd1400;
  localparam logic [10:0] PPM_KNEE     = 11'd900;
  localparam logic [7:0]  GREEN_SPAN   = 8'd38;
  localparam logic [7:0]  GREEN_BASE   = 8'd51;
  localparam logic [7:0]  HUE_GREEN    = 8'd90;
  localparam logic [7:0]  HUE_TOP      = 8'd50;
  localparam logic [7:0]  HUE_MIN      = 8'd1;
  localparam logic [7:0]  FULL_SCALE   = 8'd255;

  // Division by ten as multiply by 205 and shift by 11 (exact below 1029)
  localparam logic [7:0]  RECIP_10     = 8'd205;

  typedef enum logic [2:0] {
    REG_0 = 3'd0,
    REG_1 = 3'd1,
    REG_2 = 3'd2,
    REG_3 = 3'd3,
    REG_4 = 3'd4,
    REG_5 = 3'd5
  } region_t;

  typedef struct packed {
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
  } hsv_t;

  typedef struct packed {
    region_t    region;
    logic [7:0] rem;
    logic [7:0] s;
    logic [7:0] v;
  } sector_t;

  typedef struct packed {
    region_t    region;
    logic       szero;
    logic [7:0] v;
    logic [7:0] p;
    logic [7:0] sr;
    logic [7:0] st;
  } prod_t;

  typedef struct packed {
    region_t    region;
    logic       szero;
    logic [7:0] v;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } tone_t;

endpackage

FILE: rtl/phr_hue_map.sv
// Two pipeline stages: clamp the ppm reading, then map it to a hue and select the HSV triple.
module phr_hue_map (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [7:0]        hue,
  input  logic [7:0]        saturation,
  input  logic [7:0]        brightness,
  input  logic [15:0]       ppm,
  output logic              out_valid,
  input  logic              out_ready,
  output phr_pkg::hsv_t     out
);

  typedef struct packed {
    logic       func;
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
    logic       low;
    logic       knee;
    logic [8:0] n;
  } clamp_t;

  logic          a_vld;
  clamp_t        a;
  clamp_t        a_next;
  logic          a_ready;
  logic          b_vld;
  phr_pkg::hsv_t b;
  phr_pkg::hsv_t b_next;
  logic          b_ready;

  logic [10:0]   x;
  logic [16:0]   prod;
  logic [5:0]    q10;
  logic [7:0]    q10_w;
  logic [7:0]    d;
  logic [7:0]    map_hue;

  assign b_ready  = !b_vld || out_ready;
  assign a_ready  = !a_vld || b_ready;
  assign in_ready = a_ready;

  // Stage A: clamp to the mapped range and form the numerator of the divide by ten
  always_comb begin
    if (ppm < {5'd0, phr_pkg::PPM_LOW}) begin
      x = phr_pkg::PPM_LOW;
    end else if (ppm > {5'd0, phr_pkg::PPM_HIGH}) begin
      x = phr_pkg::PPM_HIGH;
    end else begin
      x = ppm[10:0];
    end
    a_next.func = func;
    a_next.h    = hue;
    a_next.s    = saturation;
    a_next.v    = brightness;
    a_next.low  = (x <= phr_pkg::PPM_LOW);
    a_next.knee = (x >= phr_pkg::PPM_KNEE);
    if (x >= phr_pkg::PPM_KNEE) begin
      a_next.n = 9'(x - phr_pkg::PPM_KNEE);
    end else begin
      a_next.n = 9'((x - phr_pkg::PPM_LOW) << 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_ready) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a <= a_next;
    end
  end

  // Stage B: finish the divide by ten and pick the hue band
  assign prod  = {8'd0, a.n} * {9'd0, phr_pkg::RECIP_10};
  assign q10   = prod[16:11];
  assign q10_w = {2'd0, q10};

  always_comb begin
    d = (q10_w > phr_pkg::GREEN_SPAN) ? phr_pkg::GREEN_SPAN : q10_w;
    if (a.low) begin
      map_hue = phr_pkg::HUE_GREEN;
    end else if (a.knee) begin
      map_hue = (q10_w >= phr_pkg::HUE_TOP) ? phr_pkg::HUE_MIN : 8'(phr_pkg::HUE_TOP - q10_w);
    end else begin
      map_hue = 8'(phr_pkg::GREEN_SPAN - d + phr_pkg::GREEN_BASE);
    end
    if (a.func) begin
      b_next.h = map_hue;
      b_next.s = phr_pkg::FULL_SCALE;
      b_next.v = phr_pkg::FULL_SCALE;
    end else begin
      b_next.h = a.h;
      b_next.s = a.s;
      b_next.v = a.v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (b_ready) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b <= b_next;
    end
  end

  assign out_valid = b_vld;
  assign out       = b;

endmodule

FILE: rtl/phr_region.sv
// One pipeline stage: split the hue into its sector and the scaled remainder.
module phr_region (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  phr_pkg::hsv_t     in,
  output logic              out_valid,
  input  logic              out_ready,
  output phr_pkg::sector_t  out
);

  logic             vld;
  phr_pkg::sector_t sec;
  phr_pkg::sector_t sec_next;
  logic [7:0]       base;
  logic [7:0]       off;

  assign in_ready = !vld || out_ready;

  always_comb begin
    if (in.h >= 8'(phr_pkg::REGION_WIDTH * 5)) begin
      sec_next.region = phr_pkg::REG_5;
      base            = 8'(phr_pkg::REGION_WIDTH * 5);
    end else if (in.h >= 8'(phr_pkg::REGION_WIDTH * 4)) begin
      sec_next.region = phr_pkg::REG_4;
      base            = 8'(phr_pkg::REGION_WIDTH * 4);
    end else if (in.h >= 8'(phr_pkg::REGION_WIDTH * 3)) begin
      sec_next.region = phr_pkg::REG_3;
      base            = 8'(phr_pkg::REGION_WIDTH * 3);
    end else if (in.h >= 8'(phr_pkg::REGION_WIDTH * 2)) begin
      sec_next.region = phr_pkg::REG_2;
      base            = 8'(phr_pkg::REGION_WIDTH * 2);
    end else if (in.h >= phr_pkg::REGION_WIDTH) begin
      sec_next.region = phr_pkg::REG_1;
      base            = phr_pkg::REGION_WIDTH;
    end else begin
      sec_next.region = phr_pkg::REG_0;
      base            = 8'd0;
    end
    off          = in.h - base;
    // times six, at most 252
    sec_next.rem = 8'(off << 2) + 8'(off << 1);
    sec_next.s   = in.s;
    sec_next.v   = in.v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      sec <= sec_next;
    end
  end

  assign out_valid = vld;
  assign out       = sec;

endmodule

FILE: rtl/phr_mult.sv
// Two pipeline stages of 8x8 multiplies that form the p, q and t levels.
module phr_mult (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  phr_pkg::sector_t  in,
  output logic              out_valid,
  input  logic              out_ready,
  output phr_pkg::tone_t    out
);

  function automatic logic [7:0] mul_hi(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] m;
    m = {8'd0, a} * {8'd0, b};
    return m[15:8];
  endfunction

  logic           c_vld;
  phr_pkg::prod_t c;
  phr_pkg::prod_t c_next;
  logic           c_ready;
  logic           d_vld;
  phr_pkg::tone_t d;
  phr_pkg::tone_t d_next;
  logic           d_ready;

  assign d_ready  = !d_vld || out_ready;
  assign c_ready  = !c_vld || d_ready;
  assign in_ready = c_ready;

  always_comb begin
    c_next.region = in.region;
    c_next.szero  = (in.s == 8'd0);
    c_next.v      = in.v;
    c_next.p      = mul_hi(in.v, phr_pkg::FULL_SCALE - in.s);
    c_next.sr     = mul_hi(in.s, in.rem);
    c_next.st     = mul_hi(in.s, phr_pkg::FULL_SCALE - in.rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (c_ready) begin
      c_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c <= c_next;
    end
  end

  always_comb begin
    d_next.region = c.region;
    d_next.szero  = c.szero;
    d_next.v      = c.v;
    d_next.p      = c.p;
    d_next.q      = mul_hi(c.v, phr_pkg::FULL_SCALE - c.sr);
    d_next.t      = mul_hi(c.v, phr_pkg::FULL_SCALE - c.st);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (d_ready) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      d <= d_next;
    end
  end

  assign out_valid = d_vld;
  assign out       = d;

endmodule

FILE: rtl/phr_pack.sv
// Output stage: route the levels by sector and pack them into an RGB565 register.
module phr_pack (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  phr_pkg::tone_t    in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       color
);

  logic        vld;
  logic [15:0] pix;
  logic [15:0] pix_next;
  logic [7:0]  r;
  logic [7:0]  g;
  logic [7:0]  b;

  assign in_ready = !vld || out_ready;

  always_comb begin
    unique case (in.region)
      phr_pkg::REG_0: begin r = in.v; g = in.t; b = in.p; end
      phr_pkg::REG_1: begin r = in.q; g = in.v; b = in.p; end
      phr_pkg::REG_2: begin r = in.p; g = in.v; b = in.t; end
      phr_pkg::REG_3: begin r = in.p; g = in.q; b = in.v; end
      phr_pkg::REG_4: begin r = in.t; g = in.p; b = in.v; end
      default:        begin r = in.v; g = in.p; b = in.q; end
    endcase
    // zero saturation gives black, not grey
    if (in.szero) begin
      pix_next = 16'd0;
    end else begin
      pix_next = {r[7:3], g[7:2], b[7:3]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      pix <= pix_next;
    end
  end

  assign out_valid = vld;
  assign color     = pix;

endmodule

FILE: rtl/ppm_hsv_to_rgb565_top.sv
// Top level of the ppm/HSV to RGB565 color converter pipeline.
//
// Input channel (in_valid/in_ready) carries one transaction per pixel: func
// selects HSV conversion (0, using hue/saturation/brightness) or CO2 mapping
// (1, using ppm, clamped to 800..1400 and turned into a fully saturated hue).
// Output channel (out_valid/out_ready) returns one RGB565 color per input
// transaction, in order.
//
// The pipeline has six register stages: ppm clamp, hue mapping, sector split,
// two multiply stages and the output register. Throughput is one transaction
// per cycle while the receiver keeps out_ready high; the per-stage multiplies
// set the stage depth.
//
// Each stage is ready when it is empty or its successor is ready, so bubbles
// collapse and a stalled receiver backs the pipeline up one stage at a time;
// in_ready drops only when all six stages hold data. Nothing is dropped or
// repeated while stalled. Synchronous reset empties all stages; payload
// registers are not reset.
module ppm_hsv_to_rgb565_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  input  logic [15:0] ppm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] color
);

  logic             hsv_valid;
  logic             hsv_ready;
  phr_pkg::hsv_t    hsv;
  logic             sec_valid;
  logic             sec_ready;
  phr_pkg::sector_t sec;
  logic             tone_valid;
  logic             tone_ready;
  phr_pkg::tone_t   tone;

  phr_hue_map u_hue_map (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .ppm        (ppm),
    .out_valid  (hsv_valid),
    .out_ready  (hsv_ready),
    .out        (hsv)
  );

  phr_region u_region (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsv_valid),
    .in_ready  (hsv_ready),
    .in        (hsv),
    .out_valid (sec_valid),
    .out_ready (sec_ready),
    .out       (sec)
  );

  phr_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sec_valid),
    .in_ready  (sec_ready),
    .in        (sec),
    .out_valid (tone_valid),
    .out_ready (tone_ready),
    .out       (tone)
  );

  phr_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tone_valid),
    .in_ready  (tone_ready),
    .in        (tone),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .color     (color)
  );

endmodule

FILE: rtl/phr_checker.sv
// Port-level checker for the converter top level, with its bind.
module phr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] color
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color))
    else $error("output changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // an empty output stage means the whole pipeline can advance
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while receiver takes results");

endmodule

bind ppm_hsv_to_rgb565_top phr_checker u_phr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .color     (color)
);

FILE: verif/ppm_hsv_to_rgb565_checker.sv
// Scoreboard for the ppm/HSV to RGB565 converter: predicts colors and compares results.
module ppm_hsv_to_rgb565_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [7:0]  hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  input  logic [15:0] ppm,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] color,
  output int          fault_count,
  output int          pending_colors,
  output int          colors_checked
);

  logic [15:0] expected_colors[$];
  int          faults;
  int          checked;

  function automatic logic [15:0] hsv_to_rgb565(input logic [7:0] h, input logic [7:0] s,
                                                input logic [7:0] v);
    phr_pkg::region_t sector;
    logic [31:0]      hh, ss, vv, sector_idx, rem, p, q, t, r, g, b;
    hh = h;
    ss = s;
    vv = v;
    // Zero saturation is black here, not grey
    if (ss == 0) return 16'h0000;
    sector_idx = hh / phr_pkg::REGION_WIDTH;
    rem = (hh - sector_idx * phr_pkg::REGION_WIDTH) * 6;
    sector = phr_pkg::region_t'(sector_idx);
    p = (vv * (phr_pkg::FULL_SCALE - ss)) >> 8;
    q = (vv * (phr_pkg::FULL_SCALE - ((ss * rem) >> 8))) >> 8;
    t = (vv * (phr_pkg::FULL_SCALE - ((ss * (phr_pkg::FULL_SCALE - rem)) >> 8))) >> 8;
    case (sector)
      phr_pkg::REG_0: begin r = vv; g = t;  b = p;  end
      phr_pkg::REG_1: begin r = q;  g = vv; b = p;  end
      phr_pkg::REG_2: begin r = p;  g = vv; b = t;  end
      phr_pkg::REG_3: begin r = p;  g = q;  b = vv; end
      phr_pkg::REG_4: begin r = t;  g = p;  b = vv; end
      default: begin r = vv; g = p; b = q; end
    endcase
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [7:0] co2_hue(input logic [15:0] level);
    logic [31:0] x, d;
    x = level;
    if (x < phr_pkg::PPM_LOW) x = phr_pkg::PPM_LOW;
    if (x > phr_pkg::PPM_HIGH) x = phr_pkg::PPM_HIGH;
    if (x <= phr_pkg::PPM_LOW) return phr_pkg::HUE_GREEN;
    if (x >= phr_pkg::PPM_KNEE) begin
      d = (x - phr_pkg::PPM_KNEE) / 10;
      d = phr_pkg::HUE_TOP - d;
      if (d < phr_pkg::HUE_MIN) d = phr_pkg::HUE_MIN;
      return d[7:0];
    end
    d = ((x - phr_pkg::PPM_LOW) << 2) / 10;
    if (d > phr_pkg::GREEN_SPAN) d = phr_pkg::GREEN_SPAN;
    d = phr_pkg::GREEN_SPAN - d + phr_pkg::GREEN_BASE;
    return d[7:0];
  endfunction

  task automatic note_fault(input string why, input logic [15:0] want, input logic [15:0] got);
    faults++;
    if (faults <= 10)
      $display("[%0t] %s: expected color %h, got %h", $realtime, why, want, got);
  endtask

  initial begin
    faults = 0;
    checked = 0;
    fault_count = 0;
    pending_colors = 0;
    colors_checked = 0;
  end

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (func)
          expected_colors.push_back(hsv_to_rgb565(co2_hue(ppm), phr_pkg::FULL_SCALE,
                                                  phr_pkg::FULL_SCALE));
        else
          expected_colors.push_back(hsv_to_rgb565(hue, saturation, brightness));
      end
      if (out_valid && out_ready) begin
        checked++;
        if (expected_colors.size() == 0) begin
          note_fault("color with no transaction pending", 16'h0000, color);
        end else begin
          want = expected_colors.pop_front();
          if (color !== want) note_fault("color mismatch", want, color);
        end
      end
    end
    // Publish after the edge so readers see a settled count
    fault_count    <= faults;
    pending_colors <= expected_colors.size();
    colors_checked <= checked;
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top: stimulus, flow control and verdict for the ppm/HSV to RGB565 converter.
module tb_top;

  localparam int RANDOM_ITEMS = 1625;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic [7:0]  hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;
  logic [15:0] ppm;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] color;

  int fault_count;
  int pending_colors;
  int colors_checked;

  logic choke_req;
  int   hsv_items;
  int   co2_items;
  int   black_items;
  int   steady_items;
  int   backpressure_cycles;
  int   cycle_count;

  ppm_hsv_to_rgb565_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .ppm        (ppm),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .color      (color)
  );

  ppm_hsv_to_rgb565_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .hue            (hue),
    .saturation     (saturation),
    .brightness     (brightness),
    .ppm            (ppm),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .color          (color),
    .fault_count    (fault_count),
    .pending_colors (pending_colors),
    .colors_checked (colors_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    backpressure_cycles = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && !in_ready && !rst) backpressure_cycles <= backpressure_cycles + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d colors pending",
               cycle_count, pending_colors);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_item(input logic f, input logic [7:0] h, input logic [7:0] s,
                           input logic [7:0] v, input logic [15:0] level);
    func       <= f;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    ppm        <= level;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (f) co2_items++;
    else begin
      hsv_items++;
      if (s == 8'd0) black_items++;
    end
  endtask

  // Idle the input between transactions; keep valid high when there is no gap
  task automatic pause_sender();
    int gap;
    int pick;
    gap = 0;
    if (steady_items > 0) begin
      steady_items--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 2) steady_items = $urandom_range(30, 80);
      else if (pick < 55) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : result_sink
    int stall_left;
    int steady_left;
    int pick;
    bit held;
    stall_left = 0;
    steady_left = 0;
    held = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (choke_req && !held) begin
        // Long hold-off so the pipeline fills and in_ready drops
        held = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady_left > 0) begin
        steady_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          steady_left = $urandom_range(20, 100);
          out_ready <= 1'b1;
        end else if (pick < 8) begin
          stall_left = $urandom_range(8, 30);
          out_ready <= 1'b0;
        end else if (pick < 30) begin
          stall_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    logic        f;
    logic [7:0]  h;
    logic [7:0]  s;
    logic [7:0]  v;
    logic [15:0] level;
    hsv_items = 0;
    co2_items = 0;
    black_items = 0;
    steady_items = 0;
    choke_req <= 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= 1'b0;
    hue <= 8'd0;
    saturation <= 8'd0;
    brightness <= 8'd0;
    ppm <= 16'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Hue sector edges, full and minimal saturation/value, black
    send_item(1'b0, 8'd0,   8'd255, 8'd255, 16'hFFFF); pause_sender();
    send_item(1'b0, 8'd42,  8'd255, 8'd255, 16'd0);    pause_sender();
    send_item(1'b0, 8'd43,  8'd255, 8'd255, 16'd1200); pause_sender();
    send_item(1'b0, 8'd128, 8'd255, 8'd255, 16'd0);    pause_sender();
    send_item(1'b0, 8'd171, 8'd128, 8'd200, 16'd900);  pause_sender();
    send_item(1'b0, 8'd214, 8'd255, 8'd255, 16'h5555); pause_sender();
    send_item(1'b0, 8'd215, 8'd255, 8'd255, 16'hAAAA); pause_sender();
    send_item(1'b0, 8'd255, 8'd255, 8'd255, 16'd0);    pause_sender();
    send_item(1'b0, 8'd255, 8'd255, 8'd0,   16'd0);    pause_sender();
    send_item(1'b0, 8'd100, 8'd0,   8'd255, 16'd0);    pause_sender();
    send_item(1'b0, 8'd0,   8'd0,   8'd0,   16'd0);    pause_sender();
    send_item(1'b0, 8'd255, 8'd1,   8'd1,   16'd0);    pause_sender();
    // CO2 readings around the clamps, the knee and the step boundaries
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd0);    pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd799);  pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd800);  pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd801);  pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd802);  pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd899);  pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd900);  pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd909);  pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd910);  pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd1399); pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd1400); pause_sender();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'd1401); pause_sender();
    send_item(1'b1, 8'd0,         8'd0,         8'd0,         16'hFFFF); pause_sender();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) choke_req <= 1'b1;
      f = 1'($urandom_range(0, 1));
      h = 8'($urandom);
      s = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom);
      v = 8'($urandom);
      case ($urandom_range(0, 9))
        0: level = 16'($urandom);
        1: level = 16'($urandom_range(0, 799));
        default: level = 16'($urandom_range(780, 1420));
      endcase
      send_item(f, h, s, v, level);
      pause_sender();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_colors != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d HSV (%0d with zero saturation), %0d CO2 readings",
             hsv_items + co2_items, hsv_items, black_items, co2_items);
    $display("Checked %0d colors; input stalled %0d cycles under backpressure; %0d faults",
             colors_checked, backpressure_cycles, fault_count);
    if (fault_count == 0 && pending_colors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
